/* src/bwm_pkg.sv */
// shared constants and register codes for the binarized network evaluator
package bwm_pkg;

    localparam int MAX_INPUTS_DEF = 4;
    localparam int MAX_HIDDEN_DEF = 4;
    localparam int VEC_W = 4;
    localparam int COUNT_W = 3;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] INPUT_COUNT_RST = 3'd2;
    localparam logic [COUNT_W-1:0] HIDDEN_COUNT_RST = 3'd0;
    localparam logic [WORD_W-1:0] WEIGHT_WORD_RST = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_COUNT = 2'd0,
        REG_HIDDEN_COUNT = 2'd1,
        REG_WEIGHT_WORD = 2'd2
    } cfg_reg_t;

endpackage

/* src/bwm_neuron.sv */
// one binary sign neuron: xnor match count over active terms plus a bias bit
module bwm_neuron #(
    parameter int TERMS = 4
) (
    input  logic [$clog2(TERMS+1)-1:0] active,
    input  logic [TERMS-1:0]           x,
    input  logic [TERMS:0]             w,
    output logic                       positive
);

    localparam int AW = $clog2(TERMS + 1);
    localparam int SW = $clog2(TERMS + 2) + 1;

    logic [SW-1:0] ones;
    logic [SW:0]   twice;
    logic [SW:0]   need;

    // bias sits right after the last active weight
    always_comb
    begin
        ones = SW'(w[active]);
        for (int i = 0; i < TERMS; i++)
        begin
            if ((AW'(i) < active) && (w[i] == x[i]))
            begin
                ones = ones + 1'b1;
            end
        end
        twice = {ones, 1'b0};
        need = (SW + 1)'(active) + 1'b1;
        positive = (twice >= need);
    end

endmodule

/* src/binary_weight_mlp_eval.sv */
// top level of the binarized one-hidden-layer network evaluator
// One input vector is accepted per cycle unless in_stall is raised; the first
// stage runs one neuron lane per hidden unit in parallel and registers their
// signs, the second stage evaluates the output neuron on those signs and
// registers the decision. With no hidden units, lane zero is the whole
// network. Throughput is one item per cycle as long as the output side
// does not stall; registers may be written only while no item is in flight.
module binary_weight_mlp_eval
    import bwm_pkg::*;
#(
    parameter int MAX_INPUTS = MAX_INPUTS_DEF,
    parameter int MAX_HIDDEN = MAX_HIDDEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [VEC_W-1:0]     input_vector,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 decision,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int NW = $clog2(MAX_INPUTS + 1);
    localparam int HW = $clog2(MAX_HIDDEN + 1);
    localparam int TOT = MAX_HIDDEN * (MAX_INPUTS + 1) + MAX_HIDDEN + 1;
    localparam int EXT_W = (TOT > WORD_W) ? TOT : WORD_W;
    localparam int PW = $clog2(EXT_W);

    logic [COUNT_W-1:0] input_count_reg;
    logic [COUNT_W-1:0] hidden_count_reg;
    logic [WORD_W-1:0]  weight_word_reg;

    logic [NW-1:0]         n_sat;
    logic [HW-1:0]         h_sat;
    logic [NW:0]           np1;
    logic [EXT_W-1:0]      ext;
    logic [MAX_INPUTS-1:0] xin;
    logic [MAX_HIDDEN-1:0] hid_comb;
    logic [MAX_HIDDEN-1:0] hid_reg;
    logic                  valid1_reg;
    logic                  valid1_next;
    logic                  out_valid_reg;
    logic                  decision_reg;
    logic                  s2_take;
    logic                  in_take;
    logic [PW-1:0]         obase;
    logic [EXT_W-1:0]      out_sh;
    logic                  out_sign;
    logic                  decision_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg <= INPUT_COUNT_RST;
            hidden_count_reg <= HIDDEN_COUNT_RST;
            weight_word_reg <= WEIGHT_WORD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INPUT_COUNT:  input_count_reg <= cfg_data[COUNT_W-1:0];
                REG_HIDDEN_COUNT: hidden_count_reg <= cfg_data[COUNT_W-1:0];
                REG_WEIGHT_WORD:  weight_word_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign n_sat = (int'(input_count_reg) > MAX_INPUTS) ? NW'(MAX_INPUTS)
                                                        : NW'(input_count_reg);
    assign h_sat = (int'(hidden_count_reg) > MAX_HIDDEN) ? HW'(MAX_HIDDEN)
                                                         : HW'(hidden_count_reg);
    assign np1 = {1'b0, n_sat} + 1'b1;
    assign ext = EXT_W'(weight_word_reg);

    // inputs past the field read as -1
    for (genvar i = 0; i < MAX_INPUTS; i++)
    begin : g_xin
        if (i < VEC_W)
        begin : g_in
            assign xin[i] = input_vector[i];
        end
        else
        begin : g_out
            assign xin[i] = 1'b0;
        end
    end

    // hidden lanes
    for (genvar j = 0; j < MAX_HIDDEN; j++)
    begin : g_lane
        logic [PW-1:0]    base;
        logic [EXT_W-1:0] sh;

        assign base = PW'(j) * PW'(np1);
        assign sh = ext >> base;

        bwm_neuron #(
            .TERMS(MAX_INPUTS)
        ) u_lane (
            .active(n_sat),
            .x(xin),
            .w(sh[MAX_INPUTS:0]),
            .positive(hid_comb[j])
        );
    end

    // pipeline control
    assign s2_take = !out_valid_reg || !out_stall;
    assign in_stall = valid1_reg && !s2_take;
    assign in_take = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            valid1_next = 1'b1;
        end
        else if (s2_take)
        begin
            valid1_next = 1'b0;
        end
        else
        begin
            valid1_next = valid1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hid_reg <= hid_comb;
        end
    end

    // output neuron merges the lane signs
    assign obase = PW'(h_sat) * PW'(np1);
    assign out_sh = ext >> obase;

    bwm_neuron #(
        .TERMS(MAX_HIDDEN)
    ) u_merge (
        .active(h_sat),
        .x(hid_reg),
        .w(out_sh[MAX_HIDDEN:0]),
        .positive(out_sign)
    );

    assign decision_next = (h_sat == '0) ? hid_reg[0] : out_sign;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            out_valid_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && valid1_reg)
        begin
            decision_reg <= decision_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign decision = decision_reg;

endmodule
